### hw/rtl/mahsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average hysteresis switch package
// Shared constants, register indexes and state type of the switch unit.
// ----------------------------------------------------------------------------
package mahsu_pkg;

   localparam int DEF_WINDOW_LENGTH = 8;
   localparam int DEF_SAMPLE_BITS   = 12;

   localparam int FIELD_BITS     = 12;
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DARK_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIGHT_THRESHOLD = 2'd1;

   localparam logic [FIELD_BITS-1:0] DARK_RESET  = 12'd1200;
   localparam logic [FIELD_BITS-1:0] LIGHT_RESET = 12'd1800;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_SUM,
      BK_DIV,
      BK_DECIDE,
      BK_DONE
   } back_state_type;

endpackage : mahsu_pkg
`default_nettype wire

### hw/rtl/mahsu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-entry item queue
// Holds classified items between the front and the back of the unit.
// ----------------------------------------------------------------------------
module mahsu_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : mahsu_queue
`default_nettype wire

### hw/rtl/mahsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Switch unit front end
// Accepts samples, assigns each its ring slot and divisor, and queues it.
// ----------------------------------------------------------------------------
module mahsu_front #(
   parameter int WINDOW_LENGTH = 8,
   parameter int SAMPLE_BITS   = 12,
   parameter int ENTRY_BITS    = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [mahsu_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                        push,
   output logic      [ENTRY_BITS-1:0]                  push_data,
   input  wire logic                                   queue_full
);

   import mahsu_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_LENGTH);
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   full_ff, full_in;
   logic                   wrap;
   logic [CNT_W-1:0]       divisor;
   logic [SAMPLE_BITS-1:0] sample;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign sample     = SAMPLE_BITS'(req_tdata[FIELD_BITS-1:0]);
   assign wrap       = (slot_ff == IDX_W'(WINDOW_LENGTH - 1));
   assign divisor    = (full_ff || wrap) ? CNT_W'(WINDOW_LENGTH)
                                         : CNT_W'(slot_ff) + CNT_W'(1);
   assign push_data  = ENTRY_BITS'({divisor, full_ff, slot_ff, sample});

   always_comb begin
      slot_in = slot_ff;
      full_in = full_ff;
      if (push) begin
         slot_in = wrap ? '0 : slot_ff + IDX_W'(1);
         full_in = full_ff || wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

endmodule : mahsu_front
`default_nettype wire

### hw/rtl/mahsu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Switch unit back end
// Updates the sample ring and running total, divides bit-serially and
// applies the hysteresis rule to the mean.
// ----------------------------------------------------------------------------
module mahsu_back #(
   parameter int WINDOW_LENGTH = 8,
   parameter int SAMPLE_BITS   = 12,
   parameter int ENTRY_BITS    = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [ENTRY_BITS-1:0]                pop_data,
   input  wire logic                                 queue_empty,
   output logic                                      pop,
   input  wire logic [mahsu_pkg::FIELD_BITS-1:0]     on_level,
   input  wire logic [mahsu_pkg::FIELD_BITS-1:0]     off_level,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [mahsu_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   import mahsu_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_LENGTH);
   localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + IDX_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int CMP_W  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

   back_state_type         state_ff, state_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic                   switch_ff, switch_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   old_valid_ff, old_valid_in;
   logic [CNT_W-1:0]       div_ff, div_in;
   logic [SUM_W-1:0]       dq_ff, dq_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [FIELD_BITS-1:0]  avg_ff, avg_in;

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_LENGTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic                   ring_we;

   logic [SAMPLE_BITS-1:0] old_sample;
   logic [CNT_W:0]         trial;
   logic [CNT_W:0]         trial_diff;
   logic                   trial_ge;
   logic [CMP_W-1:0]       mean_cmp;

   assign old_sample = old_valid_ff ? rdata_ff : '0;
   assign trial      = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_ge   = (trial >= {1'b0, div_ff});
   assign trial_diff = trial - {1'b0, div_ff};
   assign mean_cmp   = CMP_W'(dq_ff[SAMPLE_BITS-1:0]);
   assign ring_we    = (state_ff == BK_SUM);

   assign rsp_tvalid = (state_ff == BK_DONE);
   assign rsp_tdata  = RSP_TDATA_BITS'({switch_ff, avg_ff});

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      switch_in    = switch_ff;
      step_in      = step_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      old_valid_in = old_valid_ff;
      div_in       = div_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      avg_in       = avg_ff;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop          = 1'b1;
               sample_in    = pop_data[SAMPLE_BITS-1:0];
               slot_in      = pop_data[SAMPLE_BITS +: IDX_W];
               old_valid_in = pop_data[SAMPLE_BITS + IDX_W];
               div_in       = pop_data[SAMPLE_BITS + IDX_W + 1 +: CNT_W];
               state_in     = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_SUM;
         end
         BK_SUM: begin
            total_in = total_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            dq_in    = total_in;
            rem_in   = '0;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dq_in   = {dq_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = BK_DECIDE;
            end
         end
         BK_DECIDE: begin
            avg_in = FIELD_BITS'(dq_ff[SAMPLE_BITS-1:0]);
            if (!switch_ff && (mean_cmp < CMP_W'(on_level))) begin
               switch_in = 1'b1;
            end else if (switch_ff && (mean_cmp > CMP_W'(off_level))) begin
               switch_in = 1'b0;
            end
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (rsp_tready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         total_ff  <= '0;
         switch_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         switch_ff <= switch_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      slot_ff      <= slot_in;
      old_valid_ff <= old_valid_in;
      div_ff       <= div_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      avg_ff       <= avg_in;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= ring_mem[slot_ff];
      if (ring_we) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

endmodule : mahsu_back
`default_nettype wire

### hw/rtl/moving_average_hysteresis_switch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average hysteresis switch unit
// Averages light sensor samples over a sliding window and drives a lamp
// switch with separate dark and light thresholds.
// ----------------------------------------------------------------------------
// Each accepted sample yields one item holding the truncated mean of the last
// WINDOW_LENGTH samples (of the samples so far until the window first fills)
// and the lamp state after hysteresis. The back end reads the ring, updates
// the total, divides it with a bit-serial divider that produces one quotient
// bit per cycle, applies the hysteresis rule and then offers the item. A
// two-entry queue in front of the back end accepts new samples while a result
// is being computed or waits to be taken. Thresholds are to be written through
// the register port while the unit is idle; the block itself does not enforce
// this. The window needs no clearing after reset.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_switch_unit #(
   parameter int WINDOW_LENGTH = mahsu_pkg::DEF_WINDOW_LENGTH,
   parameter int SAMPLE_BITS   = mahsu_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [11:0] sample, [15:12] zero
   input  wire logic [mahsu_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [11:0] average, [12] lamp_on, [15:13] zero
   output logic      [mahsu_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [mahsu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mahsu_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import mahsu_pkg::*;

   localparam int IDX_W      = $clog2(WINDOW_LENGTH);
   localparam int CNT_W      = $clog2(WINDOW_LENGTH + 1);
   localparam int ENTRY_BITS = SAMPLE_BITS + IDX_W + 1 + CNT_W;

   logic [FIELD_BITS-1:0] dark_ff, dark_in;
   logic [FIELD_BITS-1:0] light_ff, light_in;
   logic                  push;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop;
   logic [ENTRY_BITS-1:0] pop_data;
   logic                  queue_full;
   logic                  queue_empty;

   always_comb begin
      dark_in  = dark_ff;
      light_in = light_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DARK_THRESHOLD:  dark_in  = FIELD_BITS'(csr_wdata);
            CSR_LIGHT_THRESHOLD: light_in = FIELD_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff  <= DARK_RESET;
         light_ff <= LIGHT_RESET;
      end else begin
         dark_ff  <= dark_in;
         light_ff <= light_in;
      end
   end

   mahsu_front #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   mahsu_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   mahsu_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .queue_empty (queue_empty),
      .pop         (pop),
      .on_level    (dark_ff),
      .off_level   (light_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule : moving_average_hysteresis_switch_unit
`default_nettype wire
